// File: src/fbfst_pkg.sv
package fbfst_pkg;

   // Field widths fixed by the item formats.
   localparam int DATA_W = 32;
   localparam int MODE_W = 2;
   localparam int LEN_W  = 5;

   // Default number of table entries.
   localparam int DEFAULT_TABLE_DEPTH = 16;

   // Search policies held in the mode register. The fourth code selects nothing.
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd1;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd2;

   // Item kinds.
   localparam logic ACT_SEARCH = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   // The search token that walks down the row of cells, carrying the pick so far.
   typedef struct packed {
      logic              valid;
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] need;
      logic              hit;
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] cap;
   } scan_token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

endpackage

// File: src/free_block_fit_search_table.sv
// Channel   Direction  tdata (lowest bit up)                         tuser
// req_      in         request_size, block_addr, block_capacity      action
// rsp_      out        found_addr, found_capacity, list_length,      found, table_full
//                      reuse_total, zero fill to 104 bits
// csr_      in         fit_mode (write only)                         -
//
// An insert item is accepted in idle; in the finish state its cell is written and its
// result posted. A search item is posted once its token has walked the row of
// TABLE_DEPTH cells, one cell per cycle. One item is worked on at a time.
// Reset clears the entry count, the reuse count, the mode register and all control state;
// the table entries themselves are not cleared. A result that waits in the output register
// does not stop the next item from being accepted; only its completion waits for the slot.
module free_block_fit_search_table #(
   parameter int TABLE_DEPTH = fbfst_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   // Input channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // request_size[31:0], block_addr[63:32],
                                     // block_capacity[95:64]
   input  logic [0:0]   req_tuser,   // action[0]
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // found_addr[31:0], found_capacity[63:32],
                                     // list_length[68:64], reuse_total[100:69], zeros above
   output logic [1:0]   rsp_tuser,   // found[0], table_full[1]
   // Configuration port.
   input  logic         csr_wr_en,
   input  logic [fbfst_pkg::MODE_W-1:0] csr_wr_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DW    = fbfst_pkg::DATA_W;

   // Mode register.
   logic [fbfst_pkg::MODE_W-1:0] fit_mode_ff;

   // Control state.
   fbfst_pkg::ctrl_state_type state_ff;
   fbfst_pkg::ctrl_state_type state_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [DW-1:0]             reuse_ff;
   logic [DW-1:0]             reuse_in;

   // The item being worked on and the pick the scan delivered.
   logic          item_action_ff;
   logic [DW-1:0] item_addr_ff;
   logic [DW-1:0] item_cap_ff;
   logic          res_hit_ff;
   logic [DW-1:0] res_addr_ff;
   logic [DW-1:0] res_cap_ff;

   // Output register.
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_found_ff;
   logic          out_full_ff;
   logic [DW-1:0] out_addr_ff;
   logic [DW-1:0] out_cap_ff;
   logic [fbfst_pkg::LEN_W-1:0] out_len_ff;
   logic [DW-1:0] out_reuse_ff;

   logic accept;
   logic capture;
   logic finish;
   logic table_at_top;
   logic do_insert;
   logic do_hit;

   fbfst_pkg::scan_token_type chain [TABLE_DEPTH+1];

   assign accept       = req_tvalid && req_tready;
   assign table_at_top = (count_ff == CNT_W'(TABLE_DEPTH));
   assign do_insert    = finish && (item_action_ff == fbfst_pkg::ACT_INSERT) && !table_at_top;
   assign do_hit       = finish && (item_action_ff == fbfst_pkg::ACT_SEARCH) && res_hit_ff;

   // A search token enters the first cell in the cycle its item is accepted.
   always_comb begin
      chain[0].valid = accept && (req_tuser[0] == fbfst_pkg::ACT_SEARCH);
      chain[0].mode  = fit_mode_ff;
      chain[0].need  = req_tdata[31:0];
      chain[0].hit   = 1'b0;
      chain[0].addr  = '0;
      chain[0].cap   = '0;
   end

   // Each cell holds one table entry. A cell counts as held once its slot lies below the count.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      fbfst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .token_in  (chain[i]),
         .held      (count_ff > CNT_W'(i)),
         .wr_en     (do_insert && (count_ff == CNT_W'(i))),
         .wr_addr   (item_addr_ff),
         .wr_cap    (item_cap_ff),
         .token_out (chain[i+1])
      );
   end

   // Sequencer: accept in idle, for a search wait for the token to leave the last cell, then post
   // the result as soon as the output register is free.
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      capture      = 1'b0;
      finish       = 1'b0;
      case (state_ff)
         fbfst_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser[0] == fbfst_pkg::ACT_SEARCH) begin
                  state_in = fbfst_pkg::ST_SCAN;
               end else begin
                  state_in = fbfst_pkg::ST_FINISH;
               end
            end
         end
         fbfst_pkg::ST_SCAN: begin
            if (chain[TABLE_DEPTH].valid) begin
               capture  = 1'b1;
               state_in = fbfst_pkg::ST_FINISH;
            end
         end
         fbfst_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               finish   = 1'b1;
               state_in = fbfst_pkg::ST_IDLE;
            end
         end
         default: state_in = fbfst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      reuse_in     = reuse_ff;
      rsp_valid_in = rsp_valid_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (do_hit) begin
         reuse_in = reuse_ff + DW'(1);
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfst_pkg::ST_IDLE;
         count_ff     <= '0;
         reuse_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fit_mode_ff  <= fbfst_pkg::FIT_FIRST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         reuse_ff     <= reuse_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fit_mode_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_action_ff <= req_tuser[0];
         item_addr_ff   <= req_tdata[63:32];
         item_cap_ff    <= req_tdata[95:64];
      end
      if (capture) begin
         res_hit_ff  <= chain[TABLE_DEPTH].hit;
         res_addr_ff <= chain[TABLE_DEPTH].addr;
         res_cap_ff  <= chain[TABLE_DEPTH].cap;
      end
      if (finish) begin
         out_found_ff <= do_hit;
         out_full_ff  <= (item_action_ff == fbfst_pkg::ACT_INSERT) && table_at_top;
         out_addr_ff  <= do_hit ? res_addr_ff : '0;
         out_cap_ff   <= do_hit ? res_cap_ff : '0;
         out_len_ff   <= fbfst_pkg::LEN_W'(count_in);
         out_reuse_ff <= reuse_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {out_full_ff, out_found_ff};
   assign rsp_tdata  = {3'b000, out_reuse_ff, out_len_ff, out_cap_ff, out_addr_ff};

`ifndef SYNTHESIS
   // The table never holds more entries than it has cells.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // A token only reaches the end of the row while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      chain[TABLE_DEPTH].valid |-> state_ff == fbfst_pkg::ST_SCAN)
      else $error("search token arrived outside a scan");

   // A scan never changes the entry count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == fbfst_pkg::ST_SCAN |=> $stable(count_ff))
      else $error("entry count moved during a scan");

   // The reuse count only ever steps up by one.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (reuse_ff != $past(reuse_ff))) |->
         (reuse_ff == DW'($past(reuse_ff) + DW'(1))))
      else $error("reuse count jumped");
`endif

endmodule

// File: src/fbfst_cell.sv
module fbfst_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fbfst_pkg::scan_token_type            token_in,
   input  logic                                 held,
   input  logic                                 wr_en,
   input  logic [fbfst_pkg::DATA_W-1:0]         wr_addr,
   input  logic [fbfst_pkg::DATA_W-1:0]         wr_cap,
   output fbfst_pkg::scan_token_type            token_out
);

   logic [fbfst_pkg::DATA_W-1:0] entry_addr_ff;
   logic [fbfst_pkg::DATA_W-1:0] entry_cap_ff;
   fbfst_pkg::scan_token_type    token_ff;
   fbfst_pkg::scan_token_type    token_in_next;
   logic                         fits;
   logic                         take;

   // This entry replaces the carried pick when it fits and the policy prefers it.
   always_comb begin
      fits = held && (entry_cap_ff >= token_in.need) &&
             ((token_in.mode == fbfst_pkg::FIT_FIRST) ||
              (token_in.mode == fbfst_pkg::FIT_WORST) ||
              (token_in.mode == fbfst_pkg::FIT_BEST));
      take = 1'b0;
      if (fits) begin
         if (!token_in.hit) begin
            take = 1'b1;
         end else begin
            case (token_in.mode)
               fbfst_pkg::FIT_WORST: take = entry_cap_ff > token_in.cap;
               fbfst_pkg::FIT_BEST:  take = entry_cap_ff <= token_in.cap;
               default:              take = 1'b0;
            endcase
         end
      end
      token_in_next = token_in;
      if (take) begin
         token_in_next.hit  = 1'b1;
         token_in_next.addr = entry_addr_ff;
         token_in_next.cap  = entry_cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_addr_ff <= wr_addr;
         entry_cap_ff  <= wr_cap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in_next.valid;
      end
      token_ff.mode <= token_in_next.mode;
      token_ff.need <= token_in_next.need;
      token_ff.hit  <= token_in_next.hit;
      token_ff.addr <= token_in_next.addr;
      token_ff.cap  <= token_in_next.cap;
   end

   assign token_out = token_ff;

endmodule

// File: sim/tb_free_block_fit_search_table.sv
module tb_free_block_fit_search_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW    = fbfst_pkg::DATA_W;
   localparam int MW    = fbfst_pkg::MODE_W;
   localparam int LW    = fbfst_pkg::LEN_W;
   localparam int DEPTH = fbfst_pkg::DEFAULT_TABLE_DEPTH;

   // Cycles without any accepted item before the run is declared hung. The slowest correct
   // stretch is a long sender gap, a full search walk and a long receiver stall, so this leaves
   // a wide margin.
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet cycles after the last result.
   localparam int DRAIN_CYCLES   = 4 * (DEPTH + 2);
   localparam int RANDOM_PHASES  = 12;

   // One input item and one result item, unpacked into their fields.
   typedef struct {
      logic          action;
      logic [DW-1:0] request_size;
      logic [DW-1:0] block_addr;
      logic [DW-1:0] block_capacity;
   } alloc_req_type;

   typedef struct {
      logic          found;
      logic [DW-1:0] found_addr;
      logic [DW-1:0] found_capacity;
      logic          table_full;
      logic [LW-1:0] list_length;
      logic [DW-1:0] reuse_total;
   } alloc_rsp_type;

   // Every input of the block is given a known value from time zero.
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [95:0]         req_tdata   = '0;   // request_size, block_addr, block_capacity
   logic [0:0]          req_tuser   = '0;   // action
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [103:0]        rsp_tdata;          // found_addr, found_capacity, list_length,
                                            // reuse_total, zero fill
   logic [1:0]          rsp_tuser;          // found, table_full
   logic                csr_wr_en   = 1'b0;
   logic [MW-1:0]       csr_wr_data = '0;

   free_block_fit_search_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Items waiting to be sent, and the results that accepted items are owed.
   alloc_req_type pending_items[$];
   alloc_rsp_type owed_results[$];
   // Items queued but not yet answered; zero means the block is idle.
   int         items_in_flight = 0;
   int         fail_count      = 0;
   // When set, neither side inserts gaps, so back-to-back traffic is covered too.
   bit         calm            = 1'b0;

   // Our own copy of the free-block table, as the block should hold it.
   logic [DW-1:0] held_addr [DEPTH];
   logic [DW-1:0] held_cap  [DEPTH];
   int            held_count  = 0;
   logic [DW-1:0] reuse_tally = '0;
   logic [MW-1:0] active_mode = fbfst_pkg::FIT_FIRST;

   // Capacities of the first DEPTH inserts, as seen by the stimulus generator. Since the driver
   // keeps the order, they are exactly what the table will hold.
   logic [DW-1:0] gen_caps[$];

   // Applies one accepted item to the table copy and returns the result it must produce.
   // A search never removes its block; only the policy in force picks which one is shown.
   function automatic alloc_rsp_type apply_fit_item(input alloc_req_type it);
      alloc_rsp_type r;
      int            pick;
      int            idx;
      r    = '{default: '0};
      pick = -1;
      if (it.action == fbfst_pkg::ACT_INSERT) begin
         if (held_count < DEPTH) begin
            held_addr[held_count] = it.block_addr;
            held_cap[held_count]  = it.block_capacity;
            held_count++;
         end else begin
            // A full table drops the block and leaves everything else untouched.
            r.table_full = 1'b1;
         end
      end else begin
         for (idx = 0; idx < held_count; idx++) begin
            if (held_cap[idx] >= it.request_size) begin
               case (active_mode)
                  fbfst_pkg::FIT_FIRST: if (pick < 0) pick = idx;
                  // Strictly larger only, so the earliest of equal maxima stays.
                  fbfst_pkg::FIT_WORST:
                     if (pick < 0 || held_cap[idx] > held_cap[pick]) pick = idx;
                  // Less or equal, so the latest of equal minima wins.
                  fbfst_pkg::FIT_BEST:
                     if (pick < 0 || held_cap[idx] <= held_cap[pick]) pick = idx;
                  // The spare mode code searches nothing at all.
                  default: ;
               endcase
            end
         end
         if (pick >= 0) begin
            r.found          = 1'b1;
            r.found_addr     = held_addr[pick];
            r.found_capacity = held_cap[pick];
            reuse_tally      = reuse_tally + DW'(1);
         end
      end
      r.list_length = held_count[LW-1:0];
      r.reuse_total = reuse_tally;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                  input logic [DW-1:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic queue_item(input logic act, input logic [DW-1:0] size,
                             input logic [DW-1:0] addr, input logic [DW-1:0] cap);
      alloc_req_type it;
      it.action         = act;
      it.request_size   = size;
      it.block_addr     = addr;
      it.block_capacity = cap;
      if (act == fbfst_pkg::ACT_INSERT && gen_caps.size() < DEPTH) gen_caps.push_back(cap);
      items_in_flight++;
      pending_items.push_back(it);
   endtask

   // The mode register may only change while the block is idle, so the sender first waits
   // for every owed result. Each call is therefore also a full drain of the pipeline.
   task automatic write_fit_mode(input logic [MW-1:0] mode);
      while (items_in_flight != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_mode  = mode;
   endtask

   // Sender. The bus is free after this edge when nothing was on it or its item was just
   // taken; only then is the next item (or a gap) chosen. Back-to-back items keep tvalid
   // high without ever lowering it in between.
   always @(posedge clock) begin : req_driver
      alloc_req_type on_bus;
      int            send_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         send_gap    = 0;
      end else begin
         if (req_tvalid && req_tready) owed_results.push_back(apply_fit_item(on_bus));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               on_bus      = pending_items.pop_front();
               req_tdata  <= {on_bus.block_capacity, on_bus.block_addr, on_bus.request_size};
               req_tuser  <= on_bus.action;
               req_tvalid <= 1'b1;
               send_gap    = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Each taken result is checked field by field against the oldest owed one;
   // stalls of random length are thrown in on the ready line.
   always @(posedge clock) begin : rsp_monitor
      alloc_rsp_type want;
      int            stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall       = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result with none owed", DW'(1), '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_tuser[0] !== want.found)
                  report_mismatch("found", DW'(rsp_tuser[0]), DW'(want.found));
               if (rsp_tuser[1] !== want.table_full)
                  report_mismatch("table_full", DW'(rsp_tuser[1]), DW'(want.table_full));
               if (rsp_tdata[31:0] !== want.found_addr)
                  report_mismatch("found_addr", rsp_tdata[31:0], want.found_addr);
               if (rsp_tdata[63:32] !== want.found_capacity)
                  report_mismatch("found_capacity", rsp_tdata[63:32], want.found_capacity);
               if (rsp_tdata[68:64] !== want.list_length)
                  report_mismatch("list_length", DW'(rsp_tdata[68:64]),
                                  DW'(want.list_length));
               if (rsp_tdata[100:69] !== want.reuse_total)
                  report_mismatch("reuse_total", rsp_tdata[100:69], want.reuse_total);
               if (rsp_tdata[103:101] !== 3'b000)
                  report_mismatch("zero fill", DW'(rsp_tdata[103:101]), '0);
               items_in_flight--;
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 15) begin
            stall       = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted item on either side restarts the count.
   always @(posedge clock) begin : hang_watch
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int            phase;
      int            count;
      int            n;
      int            roll;
      logic [DW-1:0] base;
      logic [DW-1:0] size;
      logic [DW-1:0] cap;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first under the mode that reset leaves (first fit). Searches on an
      // empty table must miss, a zero capacity fits only a zero request, and the largest
      // capacity fits the largest request.
      queue_item(fbfst_pkg::ACT_SEARCH, 32'h0000_0000, '0, '0);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'hFFFF_FFFF, '0, '0);
      queue_item(fbfst_pkg::ACT_INSERT, '0, 32'h0000_0000, 32'h0000_0000);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'h0000_0000, '0, '0);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'h0000_0001, '0, '0);
      queue_item(fbfst_pkg::ACT_INSERT, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'hFFFF_FFFF, '0, '0);
      // Pairs of equal capacities, so the tie rule of best fit gets exercised.
      queue_item(fbfst_pkg::ACT_INSERT, '0, 32'h0000_1000, 32'd100);
      queue_item(fbfst_pkg::ACT_INSERT, '0, 32'h0000_2000, 32'd100);
      queue_item(fbfst_pkg::ACT_INSERT, '0, 32'h0000_3000, 32'd50);
      queue_item(fbfst_pkg::ACT_INSERT, '0, 32'h0000_4000, 32'd50);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'd50, '0, '0);

      write_fit_mode(fbfst_pkg::FIT_WORST);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'd101, '0, '0);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'd0, '0, '0);

      // Best fit: the later of the two 50-byte and of the two 100-byte blocks must win.
      write_fit_mode(fbfst_pkg::FIT_BEST);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'd50, '0, '0);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'd100, '0, '0);
      queue_item(fbfst_pkg::ACT_SEARCH, 32'd0, '0, '0);

      // The spare mode code finds nothing, yet inserts still go in.
      write_fit_mode(MW'(3));
      queue_item(fbfst_pkg::ACT_SEARCH, 32'd0, '0, '0);
      queue_item(fbfst_pkg::ACT_INSERT, '0, 32'h0000_5000, 32'd7);

      // Random part. The table fills up early and stays full, so most items are searches
      // whose sizes sit on, just above or just below the capacities held, with some wide
      // noise. Later inserts are dropped and must be flagged as such.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_fit_mode(phase < 4 ? phase[MW-1:0] : MW'($urandom_range(0, 3)));
         calm  = (phase % 3 == 2);
         count = $urandom_range(60, 140);
         for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < (gen_caps.size() < DEPTH ? 25 : 8)) begin
               roll = $urandom_range(0, 9);
               if (roll < 4) cap = $urandom;
               else if (roll < 8) cap = $urandom_range(1, 16) * 256;
               else if (roll == 8) cap = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
               else if (gen_caps.size() != 0)
                  cap = gen_caps[$urandom_range(0, gen_caps.size() - 1)];
               else cap = $urandom;
               queue_item(fbfst_pkg::ACT_INSERT, $urandom, $urandom, cap);
            end else begin
               roll = $urandom_range(0, 9);
               base = (gen_caps.size() != 0) ?
                      gen_caps[$urandom_range(0, gen_caps.size() - 1)] : $urandom;
               if (roll < 4) size = base;
               else if (roll == 4) size = base + 1'b1;
               else if (roll == 5) size = base - 1'b1;
               else if (roll < 8) size = $urandom_range(0, 5000);
               else if (roll == 8) size = $urandom;
               else size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
               queue_item(fbfst_pkg::ACT_SEARCH, size, $urandom, $urandom);
            end
         end
      end

      // Wait for every owed result, then for the quiet cycles that catch stray outputs.
      while (items_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && owed_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
src/fbfst_pkg.sv
src/fbfst_cell.sv
src/free_block_fit_search_table.sv
sim/tb_free_block_fit_search_table.sv
